FILE: src/cte_pkg.sv
`timescale 1ns / 1ps

package cte_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_BASE_YEAR = 1900;
  localparam int unsigned DEF_YEAR_BITS = 16;

  // Field and result widths
  localparam int unsigned EPOCH_BITS  = 41;
  localparam int unsigned NARROW_BITS = 32;
  localparam int unsigned TOD_BITS    = 17;  // seconds within a day, up to 31:63:63
  localparam int unsigned DOY_BITS    = 9;   // day of shifted year plus day of month

  // Calendar constants
  localparam longint DAYS_PER_ERA    = 146097;
  localparam longint EPOCH_DAY_SHIFT = 719468;
  localparam longint SECS_PER_DAY    = 86400;

  localparam logic [TOD_BITS-1:0] SECS_PER_HOUR   = TOD_BITS'(3600);
  localparam logic [TOD_BITS-1:0] SECS_PER_MINUTE = TOD_BITS'(60);

  // January and February belong to the previous shifted year
  localparam logic [3:0] MONTH_MARCH = 4'd2;

  // Width of the biased, non-negative shifted year
  function automatic int unsigned year_pos_bits(input int unsigned year_bits);
    return (year_bits >= 12) ? year_bits + 1 : 13;
  endfunction

  // Width of the signed day count
  function automatic int unsigned day_bits(input int unsigned year_bits);
    return year_pos_bits(year_bits) + 11;
  endfunction

  // First day of each month within a year that starts in March, indexed by
  // the zero-based month. Months past December keep counting.
  function automatic logic [DOY_BITS-1:0] month_start_day(input logic [3:0] month);
    logic [DOY_BITS-1:0] day;
    unique case (month)
      4'd0:    day = DOY_BITS'(306);
      4'd1:    day = DOY_BITS'(337);
      4'd2:    day = DOY_BITS'(0);
      4'd3:    day = DOY_BITS'(31);
      4'd4:    day = DOY_BITS'(61);
      4'd5:    day = DOY_BITS'(92);
      4'd6:    day = DOY_BITS'(122);
      4'd7:    day = DOY_BITS'(153);
      4'd8:    day = DOY_BITS'(184);
      4'd9:    day = DOY_BITS'(214);
      4'd10:   day = DOY_BITS'(245);
      4'd11:   day = DOY_BITS'(275);
      4'd12:   day = DOY_BITS'(306);
      4'd13:   day = DOY_BITS'(337);
      4'd14:   day = DOY_BITS'(367);
      default: day = DOY_BITS'(398);  // month code 15
    endcase
    return day;
  endfunction

endpackage

FILE: src/cte_day_count.sv
`timescale 1ns / 1ps

module cte_day_count #(
  parameter int unsigned BASE_YEAR = cte_pkg::DEF_BASE_YEAR,
  parameter int unsigned YEAR_BITS = cte_pkg::DEF_YEAR_BITS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  output logic                                         stall_o,
  input  logic signed [YEAR_BITS-1:0]                  year_offset_i,
  input  logic [3:0]                                   month_index_i,
  input  logic [4:0]                                   day_of_month_i,
  input  logic [4:0]                                   hour_of_day_i,
  input  logic [5:0]                                   minute_of_hour_i,
  input  logic [5:0]                                   second_of_minute_i,
  output logic                                         valid_o,
  input  logic                                         stall_i,
  output logic signed [cte_pkg::day_bits(YEAR_BITS)-1:0] days_o,
  output logic [cte_pkg::TOD_BITS-1:0]                 tod_o
);
  import cte_pkg::*;

  localparam int unsigned UW = year_pos_bits(YEAR_BITS);
  localparam int unsigned DW = day_bits(YEAR_BITS);
  localparam int unsigned XW = UW - 2;   // year / 4
  localparam int unsigned QW = UW - 6;   // year / 100
  localparam int unsigned SH = XW + 5;   // reciprocal shift

  // Whole eras added so the shifted year never goes negative
  localparam longint ERA_BIAS   = (longint'(1) << (YEAR_BITS - 1)) / 400 + 1;
  localparam longint BIAS_YEARS = ERA_BIAS * 400;

  localparam logic signed [UW:0] YEAR_SHIFT = (UW+1)'(longint'(BASE_YEAR) + BIAS_YEARS);
  localparam logic [XW:0] RECIP25 = (XW+1)'(((longint'(1) << SH) + 24) / 25);
  // Epoch shift, era bias and the one-based day of month
  localparam logic signed [DW-1:0] DAY_BIAS =
    DW'(EPOCH_DAY_SHIFT + ERA_BIAS * DAYS_PER_ERA + 1);
  localparam logic signed [DW-1:0] DAYS_PER_YEAR = DW'(365);

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  assign en3     = !v3_q || !stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;
  assign valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: biased shifted year, day within shifted year, time of day
  logic                 dec_year;
  logic signed [UW:0]   yoff_x;
  logic signed [UW:0]   year_full;
  logic [UW-1:0]        year1_d, year1_q;
  logic [DOY_BITS-1:0]  doy1_d, doy1_q;
  logic [TOD_BITS-1:0]  tod1_d, tod1_q;

  assign dec_year  = month_index_i < MONTH_MARCH;
  assign yoff_x    = {{(UW+1-YEAR_BITS){year_offset_i[YEAR_BITS-1]}}, year_offset_i};
  assign year_full = yoff_x + YEAR_SHIFT - {{UW{1'b0}}, dec_year};
  assign year1_d   = year_full[UW-1:0];
  assign doy1_d    = month_start_day(month_index_i)
                   + {{(DOY_BITS-5){1'b0}}, day_of_month_i};
  assign tod1_d    = {{(TOD_BITS-5){1'b0}}, hour_of_day_i} * SECS_PER_HOUR
                   + {{(TOD_BITS-6){1'b0}}, minute_of_hour_i} * SECS_PER_MINUTE
                   + {{(TOD_BITS-6){1'b0}}, second_of_minute_i};

  always_ff @(posedge clk_i) begin
    if (en1) begin
      year1_q <= year1_d;
      doy1_q  <= doy1_d;
      tod1_q  <= tod1_d;
    end
  end

  // Stage 2: year / 100 by reciprocal, linear part of the day count
  logic [XW-1:0]        quarter;
  logic [2*XW:0]        prod;
  logic [QW-1:0]        cent2_d, cent2_q;
  logic signed [DW-1:0] base2_d, base2_q;
  logic [TOD_BITS-1:0]  tod2_q;

  assign quarter = year1_q[UW-1:2];
  assign prod    = {{(XW+1){1'b0}}, quarter} * {{XW{1'b0}}, RECIP25};
  assign cent2_d = prod[SH+QW-1:SH];
  assign base2_d = signed'({{(DW-UW){1'b0}}, year1_q}) * DAYS_PER_YEAR
                 + signed'({{(DW-XW){1'b0}}, quarter})
                 + signed'({{(DW-DOY_BITS){1'b0}}, doy1_q})
                 - DAY_BIAS;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cent2_q <= cent2_d;
      base2_q <= base2_d;
      tod2_q  <= tod1_q;
    end
  end

  // Stage 3: century and 400-year corrections
  logic signed [DW-1:0] days3_d, days3_q;
  logic [TOD_BITS-1:0]  tod3_q;

  assign days3_d = base2_q
                 - signed'({{(DW-QW){1'b0}}, cent2_q})
                 + signed'({{(DW-QW+2){1'b0}}, cent2_q[QW-1:2]});

  always_ff @(posedge clk_i) begin
    if (en3) begin
      days3_q <= days3_d;
      tod3_q  <= tod2_q;
    end
  end

  assign days_o = days3_q;
  assign tod_o  = tod3_q;

endmodule

FILE: src/cte_seconds.sv
`timescale 1ns / 1ps

module cte_seconds #(
  parameter int unsigned YEAR_BITS = cte_pkg::DEF_YEAR_BITS
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           valid_i,
  output logic                                           stall_o,
  input  logic signed [cte_pkg::day_bits(YEAR_BITS)-1:0] days_i,
  input  logic [cte_pkg::TOD_BITS-1:0]                   tod_i,
  output logic                                           valid_o,
  input  logic                                           stall_i,
  output logic signed [cte_pkg::EPOCH_BITS-1:0]          epoch_seconds_o,
  output logic signed [cte_pkg::NARROW_BITS-1:0]         narrow_seconds_o,
  output logic                                           range_error_o
);
  import cte_pkg::*;

  localparam int unsigned DW = day_bits(YEAR_BITS);
  localparam int unsigned SW = DW + 18;
  localparam logic signed [SW-1:0] SECS_DAY = SW'(SECS_PER_DAY);

  logic en4, en5;
  logic v4_q, v5_q;

  assign en5     = !v5_q || !stall_i;
  assign en4     = !v4_q || en5;
  assign stall_o = !en4;
  assign valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en4) v4_q <= valid_i;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 4: exact seconds
  logic signed [SW-1:0] secs4_d, secs4_q;

  assign secs4_d = {{(SW-DW){days_i[DW-1]}}, days_i} * SECS_DAY
                 + signed'({{(SW-TOD_BITS){1'b0}}, tod_i});

  always_ff @(posedge clk_i) begin
    if (en4) secs4_q <= secs4_d;
  end

  // Stage 5: 32-bit range check, output register
  logic [SW-NARROW_BITS:0]         upper;
  logic                            err5_d, err5_q;
  logic signed [EPOCH_BITS-1:0]    epoch5_q;
  logic signed [NARROW_BITS-1:0]   narrow5_d, narrow5_q;

  assign upper     = secs4_q[SW-1:NARROW_BITS-1];
  assign err5_d    = !((&upper) || !(|upper));
  assign narrow5_d = err5_d ? '1 : secs4_q[NARROW_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en5) begin
      epoch5_q  <= secs4_q[EPOCH_BITS-1:0];
      narrow5_q <= narrow5_d;
      err5_q    <= err5_d;
    end
  end

  assign epoch_seconds_o  = epoch5_q;
  assign narrow_seconds_o = narrow5_q;
  assign range_error_o    = err5_q;

`ifndef SYNTH
  a_err_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && range_error_o |-> narrow_seconds_o == '1)
    else $error("narrow seconds not -1 on range error");

  a_fit_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !range_error_o |-> narrow_seconds_o == epoch_seconds_o[NARROW_BITS-1:0])
    else $error("narrow seconds differ from epoch seconds");

  a_fit_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !range_error_o |->
      (&epoch_seconds_o[EPOCH_BITS-1:NARROW_BITS-1]) ||
      !(|epoch_seconds_o[EPOCH_BITS-1:NARROW_BITS-1]))
    else $error("in-range epoch seconds not sign extended");

  a_hold_stage4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !en5 |=> v4_q && $stable(secs4_q))
    else $error("stage 4 lost its transfer under stall");
`endif

endmodule

FILE: src/civil_time_to_epoch_seconds_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       receive    in_valid_i / in_stall_o   year_offset_i, month_index_i, day_of_month_i,
//                                               hour_of_day_i, minute_of_hour_i,
//                                               second_of_minute_i
// out      send       out_valid_o / out_stall_i epoch_seconds_o, narrow_seconds_o,
//                                               range_error_o
//
// One transfer in per cycle while in_stall_o is low, one result per transfer.
// The rate is set by the five-stage pipeline: stages 1-3 count days, 4-5 make seconds.
// Reset clears only the stage valid bits; no payload register is reset.
// Each stage moves when empty or when the stage after it moves, so bubbles close up
// under out_stall_i and in_stall_o rises only when all five stages are full.

module civil_time_to_epoch_seconds_unit #(
  parameter int unsigned BASE_YEAR = cte_pkg::DEF_BASE_YEAR,
  parameter int unsigned YEAR_BITS = cte_pkg::DEF_YEAR_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [YEAR_BITS-1:0]            year_offset_i,
  input  logic [3:0]                             month_index_i,
  input  logic [4:0]                             day_of_month_i,
  input  logic [4:0]                             hour_of_day_i,
  input  logic [5:0]                             minute_of_hour_i,
  input  logic [5:0]                             second_of_minute_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [cte_pkg::EPOCH_BITS-1:0]  epoch_seconds_o,
  output logic signed [cte_pkg::NARROW_BITS-1:0] narrow_seconds_o,
  output logic                                   range_error_o
);
  import cte_pkg::*;

  localparam int unsigned DW = day_bits(YEAR_BITS);

  // Day count handed from the calendar stages to the seconds stages
  logic                 days_valid;
  logic                 days_stall;
  logic signed [DW-1:0] days;
  logic [TOD_BITS-1:0]  tod;

  // Stages 1-3: shifted year and day of year, year/100 by reciprocal
  // multiply, then the leap corrections give days since the epoch.
  cte_day_count #(
    .BASE_YEAR (BASE_YEAR),
    .YEAR_BITS (YEAR_BITS)
  ) u_day_count (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (in_valid_i),
    .stall_o            (in_stall_o),
    .year_offset_i      (year_offset_i),
    .month_index_i      (month_index_i),
    .day_of_month_i     (day_of_month_i),
    .hour_of_day_i      (hour_of_day_i),
    .minute_of_hour_i   (minute_of_hour_i),
    .second_of_minute_i (second_of_minute_i),
    .valid_o            (days_valid),
    .stall_i            (days_stall),
    .days_o             (days),
    .tod_o              (tod)
  );

  // Stages 4-5: days times 86400 plus time of day, then the 32-bit check.
  cte_seconds #(
    .YEAR_BITS (YEAR_BITS)
  ) u_seconds (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (days_valid),
    .stall_o          (days_stall),
    .days_i           (days),
    .tod_i            (tod),
    .valid_o          (out_valid_o),
    .stall_i          (out_stall_i),
    .epoch_seconds_o  (epoch_seconds_o),
    .narrow_seconds_o (narrow_seconds_o),
    .range_error_o    (range_error_o)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

// Checks civil_time_to_epoch_seconds_unit. Each civil time sent in gets its
// value from the table (typed rows) or a predictor in this file. It is queued,
// and every result transfer is compared field by field against the oldest entry.

module testbench;
  import cte_pkg::*;

  localparam int unsigned BASE_YEAR = DEF_BASE_YEAR;
  localparam int unsigned YEAR_BITS = DEF_YEAR_BITS;

  // Pipeline is five stages deep; a final drain wait catches stray results.
  localparam int DRAIN_CYCLES    = 12;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 138;
  localparam int NUM_PHASES      = 4;

  localparam longint NARROW_MAX = 64'sd2147483647;
  localparam longint NARROW_MIN = -64'sd2147483648;

  // One broken-down UTC time, as the input port carries it.
  typedef struct packed {
    logic [YEAR_BITS-1:0] year_offset;
    logic [3:0]           month_index;
    logic [4:0]           day_of_month;
    logic [4:0]           hour_of_day;
    logic [5:0]           minute_of_hour;
    logic [5:0]           second_of_minute;
  } civil_time_t;

  // One result, as the output port carries it.
  typedef struct packed {
    logic [EPOCH_BITS-1:0]  epoch_seconds;
    logic [NARROW_BITS-1:0] narrow_seconds;
    logic                   range_error;
  } epoch_result_t;

  // Directed row: a time plus, where it can be written down by hand, its result.
  typedef struct packed {
    civil_time_t   stim;
    logic          typed;
    epoch_result_t want;
  } directed_row_t;

  localparam int NUM_DIRECTED = 22;

  localparam directed_row_t DIRECTED_ROWS[NUM_DIRECTED] = '{
    // 1970-01-01 00:00:00 is zero
    '{'{16'sd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1, '{41'sd0, 32'sd0, 1'b0}},
    // leap second, and the next minute that it must equal
    '{'{16'sd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd60}, 1'b1, '{41'sd60, 32'sd60, 1'b0}},
    '{'{16'sd70, 4'd0, 5'd1, 5'd0, 6'd1, 6'd0}, 1'b1, '{41'sd60, 32'sd60, 1'b0}},
    // day zero is the last day of the month before
    '{'{16'sd70, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
      '{-41'sd86400, -32'sd86400, 1'b0}},
    // hour 24 rolls into the next day
    '{'{16'sd70, 4'd0, 5'd1, 5'd24, 6'd0, 6'd0}, 1'b1,
      '{41'sd86400, 32'sd86400, 1'b0}},
    // month 12 of 1969 is January 1970
    '{'{16'sd69, 4'd12, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1, '{41'sd0, 32'sd0, 1'b0}},
    // top of the 32-bit range and one past it
    '{'{16'sd138, 4'd0, 5'd19, 5'd3, 6'd14, 6'd7}, 1'b1,
      '{41'sd2147483647, 32'h7fff_ffff, 1'b0}},
    '{'{16'sd138, 4'd0, 5'd19, 5'd3, 6'd14, 6'd8}, 1'b1,
      '{41'sd2147483648, 32'hffff_ffff, 1'b1}},
    // bottom of the 32-bit range and one below it
    '{'{16'sd1, 4'd11, 5'd13, 5'd20, 6'd45, 6'd52}, 1'b1,
      '{-41'sd2147483648, 32'h8000_0000, 1'b0}},
    '{'{16'sd1, 4'd11, 5'd13, 5'd20, 6'd45, 6'd51}, 1'b1,
      '{-41'sd2147483649, 32'hffff_ffff, 1'b1}},
    // field extremes, all high and all low
    '{'{16'sh7fff, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63}, 1'b0, '0},
    '{'{16'sh8000, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    // leap days: year 0, 1900 (not leap), 2000, then 2100-03-01
    '{'{-16'sd1900, 4'd1, 5'd29, 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{16'sd0, 4'd1, 5'd29, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{16'sd100, 4'd1, 5'd29, 5'd23, 6'd59, 6'd59}, 1'b0, '0},
    '{'{16'sd200, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    // negative years, across an era boundary
    '{'{-16'sd1901, 4'd11, 5'd31, 5'd23, 6'd59, 6'd60}, 1'b0, '0},
    '{'{-16'sd2300, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    // months past December
    '{'{16'sd100, 4'd13, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{16'sd100, 4'd14, 5'd31, 5'd1, 6'd2, 6'd3}, 1'b0, '0},
    '{'{16'sd100, 4'd15, 5'd15, 5'd31, 6'd63, 6'd63}, 1'b0, '0},
    // January day 0 in February slot: Jan 31
    '{'{16'sd70, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0}
  };

  logic                          clk;
  logic                          rst_n              = 1'b0;
  logic                          in_valid           = 1'b0;
  logic                          in_stall;
  logic signed [YEAR_BITS-1:0]   year_offset        = '0;
  logic [3:0]                    month_index        = '0;
  logic [4:0]                    day_of_month       = '0;
  logic [4:0]                    hour_of_day        = '0;
  logic [5:0]                    minute_of_hour     = '0;
  logic [5:0]                    second_of_minute   = '0;
  logic                          out_valid;
  logic                          out_stall          = 1'b0;
  logic signed [EPOCH_BITS-1:0]  epoch_seconds;
  logic signed [NARROW_BITS-1:0] narrow_seconds;
  logic                          range_error;

  // Results predicted for accepted times, oldest first.
  epoch_result_t pending_results[$];
  int            mismatches = 0;

  // Idling odds for the current phase, in percent.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold-offs: the stimulus asks, the receiver serves.
  int hold_off_requests = 0;
  int hold_offs_served  = 0;

  civil_time_to_epoch_seconds_unit #(
    .BASE_YEAR(BASE_YEAR),
    .YEAR_BITS(YEAR_BITS)
  ) i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .year_offset_i     (year_offset),
    .month_index_i     (month_index),
    .day_of_month_i    (day_of_month),
    .hour_of_day_i     (hour_of_day),
    .minute_of_hour_i  (minute_of_hour),
    .second_of_minute_i(second_of_minute),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .epoch_seconds_o   (epoch_seconds),
    .narrow_seconds_o  (narrow_seconds),
    .range_error_o     (range_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Seconds since the epoch for a civil time. Days are counted in a shifted
  // year that starts in March, so the leap day is the last day of the year;
  // years are split into 400-year eras with floor division.
  function automatic epoch_result_t epoch_of_civil(input civil_time_t t);
    longint year, month, day0, era, year_of_era, shifted_month;
    longint day_of_year, day_of_era, days, secs;
    epoch_result_t r;
    year  = longint'(BASE_YEAR) + longint'($signed(t.year_offset));
    month = longint'(t.month_index) + 1;
    day0  = longint'(t.day_of_month) - 1;
    if (month <= 2) begin
      year = year - 1;
    end
    era           = ((year >= 0) ? year : year - 399) / 400;
    year_of_era   = year - era * 400;
    shifted_month = (month > 2) ? month - 3 : month + 9;
    day_of_year   = (153 * shifted_month + 2) / 5 + day0;
    day_of_era    = year_of_era * 365 + year_of_era / 4 - year_of_era / 100 + day_of_year;
    days          = era * DAYS_PER_ERA + day_of_era - EPOCH_DAY_SHIFT;
    secs = longint'(t.second_of_minute)
         + 60 * (longint'(t.minute_of_hour) + 60 * longint'(t.hour_of_day))
         + SECS_PER_DAY * days;
    r.range_error    = (secs < NARROW_MIN) || (secs > NARROW_MAX);
    r.epoch_seconds  = EPOCH_BITS'(secs);
    r.narrow_seconds = r.range_error ? '1 : NARROW_BITS'(secs);
    return r;
  endfunction

  // Mostly plausible dates; some raw field noise and some times right at the
  // edges of the 32-bit range (December 1901 and January 2038).
  function automatic civil_time_t random_civil_time();
    civil_time_t t;
    case ($urandom_range(0, 3))
      0: begin
        t.year_offset      = YEAR_BITS'($urandom);
        t.month_index      = 4'($urandom);
        t.day_of_month     = 5'($urandom);
        t.hour_of_day      = 5'($urandom);
        t.minute_of_hour   = 6'($urandom);
        t.second_of_minute = 6'($urandom);
      end
      3: begin
        if ($urandom_range(0, 1) == 1) begin
          t.year_offset = YEAR_BITS'(1);
          t.month_index = 4'd11;
        end else begin
          t.year_offset = YEAR_BITS'(138);
          t.month_index = 4'd0;
        end
        t.day_of_month     = 5'($urandom_range(1, 31));
        t.hour_of_day      = 5'($urandom_range(0, 23));
        t.minute_of_hour   = 6'($urandom_range(0, 59));
        t.second_of_minute = 6'($urandom_range(0, 60));
      end
      default: begin
        t.year_offset      = YEAR_BITS'(int'($urandom_range(0, 400)) - 100);
        t.month_index      = 4'($urandom_range(0, 11));
        t.day_of_month     = 5'($urandom_range(1, 31));
        t.hour_of_day      = 5'($urandom_range(0, 23));
        t.minute_of_hour   = 6'($urandom_range(0, 59));
        t.second_of_minute = 6'($urandom_range(0, 60));
      end
    endcase
    return t;
  endfunction

  // Offers one time and returns in the step where it was transferred. Valid
  // is left high so back-to-back items need no extra assignment.
  task automatic send_civil_time(input civil_time_t t, input logic typed,
                                 input epoch_result_t typed_result);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    year_offset      <= t.year_offset;
    month_index      <= t.month_index;
    day_of_month     <= t.day_of_month;
    hour_of_day      <= t.hour_of_day;
    minute_of_hour   <= t.minute_of_hour;
    second_of_minute <= t.second_of_minute;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_results.push_back(typed ? typed_result : epoch_of_civil(t));
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic drain_pending();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results.size() != 0);
  endtask

  task automatic report_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endtask

  // Receiver: checks each result transfer, then picks the next stall value.
  initial begin
    epoch_result_t want;
    int            hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, epoch_seconds %0d", $time, epoch_seconds);
        end else begin
          want = pending_results.pop_front();
          if (epoch_seconds !== want.epoch_seconds) begin
            report_field("epoch_seconds", $signed(want.epoch_seconds), epoch_seconds);
          end
          if (narrow_seconds !== want.narrow_seconds) begin
            report_field("narrow_seconds", $signed(want.narrow_seconds), narrow_seconds);
          end
          if (range_error !== want.range_error) begin
            report_field("range_error", want.range_error, range_error);
          end
        end
      end
      if (hold_offs_served < hold_off_requests) begin
        hold_offs_served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Stimulus: reset, the directed table, then random phases with different
  // idling. Each phase starts with the pipeline empty.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      send_civil_time(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_pending();
      case (phase)
        0: begin
          // Full rate with a long output hold-off: the pipe fills and stalls.
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_off_requests++;
        end
        1: begin
          send_idle_pct  = 68;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 68;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
          hold_off_requests++;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_civil_time(random_civil_time(), 1'b0, '0);
      end
    end

    drain_pending();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("civil_time_to_epoch_seconds_unit: match");
    end else begin
      $display("civil_time_to_epoch_seconds_unit: mismatch");
    end
    $finish;
  end

  // Watchdog: a correct run ends far sooner.
  initial begin
    #2_000_000;
    $display("civil_time_to_epoch_seconds_unit: mismatch");
    $finish;
  end

endmodule
